>>> rtl/length_prefixed_frame_crc_check_assert.svh
// assertion macros for the frame crc checker
// used by the checker module, no other dependencies
`ifndef LENGTH_PREFIXED_FRAME_CRC_CHECK_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_CRC_CHECK_ASSERT_SVH

// same-cycle implication, masked during reset
`define LPFCC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpfcc assertion failed");

// next-cycle implication, masked during reset
`define LPFCC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpfcc assertion failed");

`endif

>>> rtl/lpfcc_pkg.sv
// shared widths, crc constants and the per-byte crc-16/modbus update
// no dependencies; used by the top level and the checker
package lpfcc_pkg;

  localparam int BYTE_W = 8;
  localparam int CRC_W  = 16;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

  // reflected crc, one byte, eight shift steps
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> rtl/length_prefixed_frame_crc_check.sv
// length-prefixed frame checker with crc-16/modbus over all but the last two bytes
// depends on lpfcc_pkg
//
//   port group  | direction | handshake           | payload
//   ------------+-----------+---------------------+----------------------------------
//   input byte  | in        | in_valid / in_stall | data_byte
//   frame check | out       | out_valid/out_stall | frame_ok, computed_crc, received_crc
//
// one byte per cycle while the output register is not full and stalled: the input
// register feeds a single crc byte update and the frame state, whose result lands
// in the output register, reached by the frame's last byte after the input register.
// rst is synchronous and active high; it empties both registers and waits for a length.
// in_stall rises only while a byte is held and the output register is full and stalled.
module length_prefixed_frame_crc_check (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lpfcc_pkg::BYTE_W-1:0]  data_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          frame_ok,
  output logic [lpfcc_pkg::CRC_W-1:0]   computed_crc,
  output logic [lpfcc_pkg::CRC_W-1:0]   received_crc
);

  // input register
  logic                         s1_valid;
  logic [lpfcc_pkg::BYTE_W-1:0] s1_byte;

  // frame state
  logic                         awaiting_length, awaiting_length_next;
  logic [lpfcc_pkg::BYTE_W-1:0] frame_length, frame_length_next;
  logic [lpfcc_pkg::BYTE_W-1:0] bytes_seen, bytes_seen_next;
  logic [lpfcc_pkg::CRC_W-1:0]  crc_acc, crc_acc_next;
  logic [lpfcc_pkg::BYTE_W-1:0] first_check_byte, first_check_byte_next;

  logic                         advance;
  logic                         emit;
  logic                         res_ok;
  logic [lpfcc_pkg::CRC_W-1:0]  res_computed;
  logic [lpfcc_pkg::CRC_W-1:0]  res_received;
  logic [lpfcc_pkg::BYTE_W:0]   len_ext;
  logic [lpfcc_pkg::BYTE_W:0]   idx_inc;
  logic [lpfcc_pkg::BYTE_W:0]   idx_inc2;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  assign len_ext  = {1'b0, frame_length};
  assign idx_inc  = {1'b0, bytes_seen} + 9'd1;
  assign idx_inc2 = {1'b0, bytes_seen} + 9'd2;

  always_comb begin
    awaiting_length_next  = awaiting_length;
    frame_length_next     = frame_length;
    bytes_seen_next       = bytes_seen;
    crc_acc_next          = crc_acc;
    first_check_byte_next = first_check_byte;
    emit                  = 1'b0;
    res_ok                = 1'b0;
    res_computed          = '0;
    res_received          = '0;
    if (advance) begin
      if (awaiting_length) begin
        if (s1_byte == '0) begin
          // empty frame: result straight from the length byte
          emit = 1'b1;
        end else begin
          frame_length_next     = s1_byte;
          bytes_seen_next       = '0;
          crc_acc_next          = lpfcc_pkg::CRC_INIT;
          first_check_byte_next = '0;
          awaiting_length_next  = 1'b0;
        end
      end else begin
        if (idx_inc2 < len_ext) begin
          crc_acc_next = lpfcc_pkg::crc_byte(crc_acc, s1_byte);
        end else if (idx_inc2 == len_ext) begin
          first_check_byte_next = s1_byte;
        end
        bytes_seen_next = idx_inc[lpfcc_pkg::BYTE_W-1:0];
        if (!(idx_inc < len_ext)) begin
          emit = 1'b1;
          if (frame_length >= 8'd3) begin
            res_received = {s1_byte, first_check_byte};
            res_computed = crc_acc;
            res_ok       = (res_received == crc_acc);
          end
          awaiting_length_next  = 1'b1;
          frame_length_next     = '0;
          bytes_seen_next       = '0;
          crc_acc_next          = lpfcc_pkg::CRC_INIT;
          first_check_byte_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_length  <= 1'b1;
      frame_length     <= '0;
      bytes_seen       <= '0;
      crc_acc          <= lpfcc_pkg::CRC_INIT;
      first_check_byte <= '0;
    end else begin
      awaiting_length  <= awaiting_length_next;
      frame_length     <= frame_length_next;
      bytes_seen       <= bytes_seen_next;
      crc_acc          <= crc_acc_next;
      first_check_byte <= first_check_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      frame_ok     <= res_ok;
      computed_crc <= res_computed;
      received_crc <= res_received;
    end
  end

endmodule

>>> rtl/lpfcc_checker.sv
// port-level checks for the frame crc checker, bound onto the top level
// depends on lpfcc_pkg and length_prefixed_frame_crc_check_assert.svh
`include "length_prefixed_frame_crc_check_assert.svh"

module lpfcc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [lpfcc_pkg::BYTE_W-1:0] data_byte,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         frame_ok,
  input logic [lpfcc_pkg::CRC_W-1:0]  computed_crc,
  input logic [lpfcc_pkg::CRC_W-1:0]  received_crc
);

  logic in_xfer;
  assign in_xfer = in_valid && !in_stall && (data_byte == data_byte);

  // a good frame must carry matching crcs
  `LPFCC_ASSERT_IMP(a_ok_matches, clk, rst, out_valid && frame_ok, computed_crc == received_crc)

  // the input side only backs up when the result register is full and stalled
  `LPFCC_ASSERT_IMP(a_stall_cause, clk, rst, in_stall, out_valid && out_stall)

  // a stalled result keeps its payload
  `LPFCC_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall,
                    out_valid && $stable(frame_ok) && $stable(computed_crc) && $stable(received_crc))

  // a fresh result needs an earlier transfer on the input
  `LPFCC_ASSERT_IMP(a_out_cause, clk, rst, $rose(out_valid), $past(in_xfer, 2))

endmodule

bind length_prefixed_frame_crc_check lpfcc_checker u_lpfcc_checker (.*);

>>> verif/length_prefixed_frame_crc_check_checker.sv
`timescale 1ns / 100ps
// byte-wise crc-16/modbus helper and the checker for the frame crc block
// the checker watches both channels, predicts each frame verdict and compares
// depends on lpfcc_pkg for widths and crc constants
package lpfcc_tb_pkg;

  import lpfcc_pkg::*;

  // reflected update, one bit per pass, lsb first
  function automatic logic [CRC_W-1:0] modbus_crc_byte(input logic [CRC_W-1:0] acc,
                                                       input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] r;
    r = acc ^ {8'h00, b};
    repeat (BYTE_W) r = {1'b0, r[CRC_W-1:1]} ^ (r[0] ? CRC_POLY : '0);
    return r;
  endfunction

endpackage

module length_prefixed_frame_crc_check_checker
  import lpfcc_pkg::*;
  import lpfcc_tb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              frame_ok,
  input  logic [CRC_W-1:0]  computed_crc,
  input  logic [CRC_W-1:0]  received_crc,
  output int unsigned       fail_count,
  output int unsigned       pending
);

  typedef struct packed {
    logic              ok;
    logic [CRC_W-1:0]  crc;
    logic [CRC_W-1:0]  rx;
  } frame_verdict_t;

  frame_verdict_t verdict_q[$];

  logic              want_length;
  logic [BYTE_W-1:0] frame_len;
  logic [BYTE_W-1:0] byte_idx;
  logic [BYTE_W-1:0] check_lo;
  logic [CRC_W-1:0]  crc_run;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    frame_verdict_t v;
    frame_verdict_t seen;
    if (rst) begin
      want_length = 1'b1;
      frame_len   = '0;
      byte_idx    = '0;
      check_lo    = '0;
      crc_run     = CRC_INIT;
      verdict_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (want_length) begin
          // an empty frame is judged on its length byte alone
          if (data_byte == '0) begin
            verdict_q.push_back('0);
          end else begin
            frame_len   = data_byte;
            byte_idx    = '0;
            crc_run     = CRC_INIT;
            check_lo    = '0;
            want_length = 1'b0;
          end
        end else begin
          if (frame_len >= 2 && byte_idx + 2 < frame_len) begin
            crc_run = modbus_crc_byte(crc_run, data_byte);
          end else if (frame_len >= 2 && byte_idx + 2 == frame_len) begin
            check_lo = data_byte;
          end
          if (byte_idx + 1 == frame_len) begin
            if (frame_len >= 3) begin
              v.rx  = {data_byte, check_lo};
              v.crc = crc_run;
              v.ok  = (v.rx == v.crc);
            end else begin
              v = '0;
            end
            verdict_q.push_back(v);
            want_length = 1'b1;
          end
          byte_idx = byte_idx + 1'b1;
        end
      end

      if (out_valid && !out_stall) begin
        seen = '{ok: frame_ok, crc: computed_crc, rx: received_crc};
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result, got ok %0b crc %h rx %h",
                   $time, seen.ok, seen.crc, seen.rx);
          fail_count++;
        end else begin
          v = verdict_q.pop_front();
          if (seen.ok !== v.ok) begin
            $display("%0t: frame_ok mismatch, expected %0b, got %0b", $time, v.ok, seen.ok);
            fail_count++;
          end
          if (seen.crc !== v.crc) begin
            $display("%0t: computed_crc mismatch, expected %h, got %h",
                     $time, v.crc, seen.crc);
            fail_count++;
          end
          if (seen.rx !== v.rx) begin
            $display("%0t: received_crc mismatch, expected %h, got %h",
                     $time, v.rx, seen.rx);
            fail_count++;
          end
        end
      end
    end
    pending <= verdict_q.size();
  end

endmodule

>>> verif/length_prefixed_frame_crc_check_tb.sv
`timescale 1ns / 100ps
// top of the frame crc checker testbench: clock, reset, byte stimulus and verdict
// depends on lpfcc_pkg, lpfcc_tb_pkg and the checker module
module length_prefixed_frame_crc_check_tb;

  import lpfcc_pkg::*;
  import lpfcc_tb_pkg::*;

  localparam int unsigned RANDOM_BYTES = 1750;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] data_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              frame_ok;
  logic [CRC_W-1:0]  computed_crc;
  logic [CRC_W-1:0]  received_crc;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned bytes_sent     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  length_prefixed_frame_crc_check i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_ok     (frame_ok),
    .computed_crc (computed_crc),
    .received_crc (received_crc)
  );

  length_prefixed_frame_crc_check_checker i_chk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_ok     (frame_ok),
    .computed_crc (computed_crc),
    .received_crc (received_crc),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < recv_stall_pct);
  end

  // valid stays up between back-to-back bytes, dropped only for idle cycles
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // fill below zero gives random body bytes; from length three up the trailer carries the crc unless corrupted
  task automatic send_frame(input int unsigned len, input int fill, input bit corrupt);
    logic [BYTE_W-1:0] frame_q[$];
    logic [BYTE_W-1:0] b;
    logic [CRC_W-1:0]  crc;
    int unsigned       k;
    int unsigned       pos;
    crc = CRC_INIT;
    for (k = 0; k < len; k++) begin
      if (len >= 3 && k == len - 2) begin
        b = crc[7:0];
      end else if (len >= 3 && k == len - 1) begin
        b = crc[15:8];
      end else begin
        b = (fill < 0) ? BYTE_W'($urandom_range(255)) : BYTE_W'(fill);
        if (len >= 3) crc = modbus_crc_byte(crc, b);
      end
      frame_q.push_back(b);
    end
    if (corrupt && len >= 3) begin
      pos = $urandom_range(len - 1);
      frame_q[pos] = frame_q[pos] ^ (8'h01 << $urandom_range(7));
    end
    send_byte(BYTE_W'(len));
    foreach (frame_q[i]) send_byte(frame_q[i]);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned phase;
    int unsigned target;
    int unsigned pick;
    int unsigned len;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty frames back to back, then the short lengths
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(3, 8'h00, 1'b0);
    send_frame(3, 8'hFF, 1'b0);
    send_frame(4, -1, 1'b0);
    send_frame(4, -1, 1'b1);
    drain();

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 33;
          recv_stall_pct = 57;
        end
        1: begin
          send_idle_pct  = 57;
          recv_stall_pct = 33;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      target = bytes_sent + RANDOM_BYTES / 3;
      while (bytes_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 3)      len = 0;
        else if (pick < 8) len = $urandom_range(1, 2);
        else if (pick < 9) len = $urandom_range(64, 255);
        else               len = $urandom_range(3, 16);
        send_frame(len, -1, $urandom_range(3) == 0);
      end
      // hold off until every verdict of this phase is out
      drain();
    end

    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/lpfcc_pkg.sv
rtl/length_prefixed_frame_crc_check.sv
rtl/lpfcc_checker.sv
verif/length_prefixed_frame_crc_check_checker.sv
verif/length_prefixed_frame_crc_check_tb.sv
